### rtl/sapq_pkg.sv
package sapq_pkg;

  localparam int DEPTH = 8;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef enum logic [0:0] {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture incoming request
    logic exec;   // apply request to array, update result register
  } cmd_t;

endpackage

### rtl/sapq_ctrl.sv
module sapq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output sapq_pkg::cmd_t cmd
);
  import sapq_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid && out_free) state_next = S_EXEC;
      S_EXEC: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        s_tready = out_free;
        cmd.load = s_tvalid && out_free;
      end
      S_EXEC: cmd.exec = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

### rtl/sapq_dp.sv
module sapq_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  sapq_pkg::cmd_t               cmd,
  input  logic                         req_type,
  input  logic signed [31:0]           value_in,
  output logic [1:0]                   status,
  output logic signed [31:0]           value_out,
  output logic [sapq_pkg::CNT_W-1:0]   occupancy
);
  import sapq_pkg::*;

  logic signed [VAL_W-1:0] entries [DEPTH];
  logic signed [VAL_W-1:0] entries_next [DEPTH];
  logic [CNT_W-1:0]        fill_count, fill_count_next;
  logic                    req_q;
  logic signed [VAL_W-1:0] val_q;
  logic [DEPTH-1:0]        shift_up;   // slot holds an entry greater than val_q
  logic                    full, empty;
  logic                    do_ins, do_rem;

  assign full   = (fill_count == CNT_FULL);
  assign empty  = (fill_count == '0);
  assign do_ins = (req_q == REQ_INSERT) && !full;
  assign do_rem = (req_q == REQ_REMOVE) && !empty;

  // one compare cell per slot
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      shift_up[i] = (CNT_W'(i) < fill_count) && (entries[i] > val_q);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_next[i] = entries[i];
      if (do_ins) begin
        if (i > 0 && shift_up[(i > 0) ? i - 1 : 0])
          entries_next[i] = entries[(i > 0) ? i - 1 : 0];
        else if (shift_up[i] || CNT_W'(i) == fill_count)
          entries_next[i] = val_q;
      end else if (do_rem && i < DEPTH - 1) begin
        entries_next[i] = entries[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
    fill_count_next = fill_count;
    if (do_ins)      fill_count_next = fill_count + 1'b1;
    else if (do_rem) fill_count_next = fill_count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) fill_count <= '0;
    else if (cmd.exec) fill_count <= fill_count_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_type;
      val_q <= value_in;
    end
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) entries[i] <= entries_next[i];
      occupancy <= fill_count_next;
      value_out <= do_rem ? entries[0] : '0;
      if (req_q == REQ_INSERT) status <= full ? ST_OVERFLOW : ST_OK;
      else                     status <= empty ? ST_UNDERFLOW : ST_OK;
    end
  end

endmodule

### rtl/sorted_array_priority_queue.sv
// Sorted-array min-priority queue, DEPTH signed 32-bit entries.
// Result: the request is captured when accepted, then applied to the array
//   and registered in the execute state, and held until its handshake.
// Requests: a new request is not accepted until the last one has executed
//   and the result register is free or being drained (accept/execute pair).
// Reset: rst (synchronous, active high) empties the queue and drops any
//   pending result; array contents are not cleared.
module sorted_array_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value_in
  input  logic [0:0]  s_tuser,   // [0] req_type (0 insert, 1 remove)
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] value_out, [35:32] occupancy, [39:36] zero
  output logic [1:0]  m_tuser    // [1:0] status
);
  import sapq_pkg::*;

  cmd_t                    cmd;
  logic signed [VAL_W-1:0] value_out;
  logic [CNT_W-1:0]        occupancy;

  // Controller: accepts one request when the result register is free or
  // being drained, then issues a single execute cycle.
  sapq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Datapath: per-slot compare cells decide shift/place on insert; remove
  // shifts everything down one slot. Result register lives here too.
  sapq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_type  (s_tuser[0]),
    .value_in  ($signed(s_tdata)),
    .status    (m_tuser),
    .value_out (value_out),
    .occupancy (occupancy)
  );

  // occupancy goes out as its low four bits
  always_comb begin
    m_tdata        = '0;
    m_tdata[31:0]  = value_out;
    m_tdata[35:32] = 4'(occupancy);
  end

endmodule

### rtl/sapq_checker.sv
module sapq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import sapq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 m_tvalid)
    else $error("accepted request did not produce a result");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_UNDERFLOW |-> m_tdata[35:0] == 36'd0)
    else $error("underflow with nonzero value or occupancy");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_OVERFLOW
      |-> m_tdata[35:32] == 4'(DEPTH) && m_tdata[31:0] == 32'd0)
    else $error("overflow while not full");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
